// ----- hdl/jrd_pkg.sv -----
// ----------------------------------------------------------------------------
// jrd_pkg: shared types and constants
// Widths of the conditioning datapath, register indexes and bundles.
// ----------------------------------------------------------------------------
package jrd_pkg;

    localparam int AX_W     = 29;   // signed conditioned axis, Q.24
    localparam int MAG_W    = 28;   // axis magnitude
    localparam int SUM_W    = 56;   // sum of squares
    localparam int R_W      = 28;   // radius
    localparam int NUM_W    = 56;   // divider dividend
    localparam int DEN_W    = 32;   // divider divisor
    localparam int F_W      = 25;   // length factor, up to 1.0 in Q.24
    localparam int C_W      = 26;   // signed scaled axis
    localparam int OUT_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

    typedef struct packed {
        logic signed [15:0] x_center;
        logic signed [15:0] y_center;
        logic [16:0]        deadzone;
        logic [15:0]        range_divisor;
        logic [14:0]        threshold;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

// ----- hdl/jrd_front.sv -----
// ----------------------------------------------------------------------------
// jrd_front: sample intake
// Drops repeated samples and buffers new ones in a two-entry queue.
// ----------------------------------------------------------------------------
module jrd_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [SAMPLE_BITS-1:0] raw_x_in,
    input  logic [SAMPLE_BITS-1:0] raw_y_in,
    output logic                   q_valid,
    input  logic                   q_pop,
    output logic [SAMPLE_BITS-1:0] q_x,
    output logic [SAMPLE_BITS-1:0] q_y
);

    logic [SAMPLE_BITS-1:0] prev_x_reg, prev_y_reg;
    logic [SAMPLE_BITS-1:0] mem_x [2];
    logic [SAMPLE_BITS-1:0] mem_y [2];
    logic                   wr_ptr_reg, rd_ptr_reg;
    logic [1:0]             cnt_reg;
    logic                   accept, enq, deq;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign accept  = push && !full;
    assign enq     = accept && !(raw_x_in == prev_x_reg && raw_y_in == prev_y_reg);
    assign deq     = q_pop && q_valid;
    assign q_x     = mem_x[rd_ptr_reg];
    assign q_y     = mem_y[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem_x[wr_ptr_reg] <= raw_x_in;
            mem_y[wr_ptr_reg] <= raw_y_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                prev_x_reg <= raw_x_in;
                prev_y_reg <= raw_y_in;
            end
            if (enq)
                wr_ptr_reg <= !wr_ptr_reg;
            if (deq)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, enq} - {1'b0, deq};
        end
    end

endmodule

// ----- hdl/jrd_div.sv -----
// ----------------------------------------------------------------------------
// jrd_div: shared unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jrd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  jrd_pkg::div_req_t req,
    output jrd_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(jrd_pkg::NUM_W);

    logic [jrd_pkg::DEN_W-1:0] rem_reg, den_reg;
    logic [jrd_pkg::NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg, done_reg;
    logic [jrd_pkg::DEN_W:0]   trial;
    logic                      fits;

    assign trial = {rem_reg, quo_reg[jrd_pkg::NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                den_reg  <= req.den;
                quo_reg  <= req.num;
                cnt_reg  <= CNT_W'(jrd_pkg::NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (fits)
                    rem_reg <= jrd_pkg::DEN_W'(trial - {1'b0, den_reg});
                else
                    rem_reg <= trial[jrd_pkg::DEN_W-1:0];
                quo_reg <= {quo_reg[jrd_pkg::NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hdl/jrd_back.sv -----
// ----------------------------------------------------------------------------
// jrd_back: conditioning sequencer
// Offset, radius, deadzone scaling, output rounding and direction flags, with result register.
// ----------------------------------------------------------------------------
module jrd_back #(
    parameter int SAMPLE_BITS  = 16,
    parameter int OUTPUT_SCALE = 272
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  jrd_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  logic [SAMPLE_BITS-1:0]        q_x,
    input  logic [SAMPLE_BITS-1:0]        q_y,
    output jrd_pkg::div_req_t             div_req,
    input  jrd_pkg::div_rsp_t             div_rsp,
    output logic                          empty,
    input  logic                          pop,
    output logic [jrd_pkg::OUT_W-1:0]     stick_x,
    output logic [jrd_pkg::OUT_W-1:0]     stick_y,
    output logic                          dir_right,
    output logic                          dir_left,
    output logic                          dir_up,
    output logic                          dir_down
);

    localparam int AX_W  = jrd_pkg::AX_W;
    localparam int MAG_W = jrd_pkg::MAG_W;
    localparam int C_W   = jrd_pkg::C_W;
    localparam int F_W   = jrd_pkg::F_W;
    localparam int SHIFT = 25 - SAMPLE_BITS;
    localparam logic [14:0] SCALE = 15'(OUTPUT_SCALE);

    typedef enum logic [3:0] {
        S_IDLE, S_OFFS, S_ODIV, S_SQ, S_SUM, S_SQRT,
        S_LEN, S_LWAIT, S_SCL, S_SWAIT, S_OUT
    } state_t;

    state_t                         state_reg;
    logic                           sel_reg;
    logic signed [AX_W-1:0]         vx_reg, vy_reg;
    logic signed [C_W-1:0]          cx_reg, cy_reg;
    logic [jrd_pkg::SUM_W-1:0]      sqx_reg, sqy_reg, n_reg, res_reg, bit_reg;
    logic [jrd_pkg::R_W-1:0]        r_reg;
    logic [F_W-1:0]                 f_reg;
    jrd_pkg::div_req_t              div_req_reg;
    logic                           out_valid_reg;
    logic [jrd_pkg::OUT_W-1:0]      sx_reg, sy_reg;
    logic [3:0]                     dir_reg;

    logic signed [AX_W-1:0]         sel_v, load_x, load_y, odiv_v;
    logic signed [15:0]             sel_off;
    logic                           sel_neg, off_small;
    logic [MAG_W-1:0]               sel_mag;
    logic signed [17:0]             off_den;
    logic [jrd_pkg::SUM_W-1:0]      trial;
    logic [23:0]                    dz24;
    logic                           in_zone;
    logic [15:0]                    rng;
    logic [32:0]                    len_den;
    logic signed [C_W-1:0]          scl_c, thr_c;
    logic                           slot_free;

    function automatic logic [jrd_pkg::OUT_W-1:0] to_out(input logic signed [C_W-1:0] c);
        logic [C_W-1:0] m;
        logic [40:0]    p;
        logic [jrd_pkg::OUT_W-1:0] q;
        m = c[C_W-1] ? C_W'(-c) : C_W'(c);
        p = 41'(m[F_W-1:0]) * 41'(SCALE) + (41'd1 << 23);
        q = p[24 +: jrd_pkg::OUT_W];
        return c[C_W-1] ? jrd_pkg::OUT_W'(-q) : q;
    endfunction

    assign sel_v   = sel_reg ? vy_reg : vx_reg;
    assign sel_off = sel_reg ? cfg.y_center : cfg.x_center;
    assign sel_neg = sel_v[AX_W-1];
    assign sel_mag = sel_neg ? MAG_W'(-sel_v) : MAG_W'(sel_v);
    assign off_small = (sel_off > -16'sd24576) && (sel_off < 16'sd24576);
    assign off_den = (!sel_neg && sel_v != '0) ? 18'sd32768 + 18'(sel_off)
                                               : 18'sd32768 - 18'(sel_off);
    assign odiv_v  = sel_neg ? -AX_W'(div_rsp.quot[MAG_W-1:0])
                             : AX_W'(div_rsp.quot[MAG_W-1:0]);

    assign load_x = (AX_W'(signed'(q_x)) <<< SHIFT) + (AX_W'(cfg.x_center) <<< 9);
    assign load_y = (AX_W'(signed'(q_y)) <<< SHIFT) + (AX_W'(cfg.y_center) <<< 9);

    assign trial   = n_reg - (res_reg + bit_reg);
    assign dz24    = {cfg.deadzone[15:0], 8'd0};
    assign in_zone = !cfg.deadzone[16] && (r_reg > jrd_pkg::R_W'(dz24));
    assign rng     = (cfg.range_divisor == '0) ? 16'd1 : cfg.range_divisor;
    assign len_den = (17'd65536 - cfg.deadzone) * rng;
    assign scl_c   = sel_neg ? -C_W'(div_rsp.quot[F_W-1:0]) : C_W'(div_rsp.quot[F_W-1:0]);
    assign thr_c   = C_W'({cfg.threshold, 9'd0});
    assign slot_free = !out_valid_reg || pop;

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign div_req   = div_req_reg;
    assign empty     = !out_valid_reg;
    assign stick_x   = sx_reg;
    assign stick_y   = sy_reg;
    assign dir_right = dir_reg[0];
    assign dir_left  = dir_reg[1];
    assign dir_up    = dir_reg[2];
    assign dir_down  = dir_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            div_req_reg   <= '0;
            out_valid_reg <= 1'b0;
            vx_reg <= '0;  vy_reg <= '0;
            cx_reg <= '0;  cy_reg <= '0;
            sqx_reg <= '0; sqy_reg <= '0;
            n_reg <= '0;   res_reg <= '0; bit_reg <= '0;
            r_reg <= '0;   f_reg <= '0;
            sx_reg <= '0;  sy_reg <= '0;  dir_reg <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        vx_reg    <= load_x;
                        vy_reg    <= load_y;
                        sel_reg   <= 1'b0;
                        state_reg <= S_OFFS;
                    end
                end
                S_OFFS:
                begin
                    if (off_small)
                    begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= jrd_pkg::NUM_W'(sel_mag) << 15;
                        div_req_reg.den   <= jrd_pkg::DEN_W'(off_den[15:0]);
                        state_reg         <= S_ODIV;
                    end
                    else if (sel_reg)
                        state_reg <= S_SQ;
                    else
                        sel_reg <= 1'b1;
                end
                S_ODIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (sel_reg)
                        begin
                            vy_reg    <= odiv_v;
                            state_reg <= S_SQ;
                        end
                        else
                        begin
                            vx_reg    <= odiv_v;
                            sel_reg   <= 1'b1;
                            state_reg <= S_OFFS;
                        end
                    end
                end
                S_SQ:
                begin
                    sqx_reg <= jrd_pkg::SUM_W'(MAG_W'(vx_reg[AX_W-1] ? -vx_reg : vx_reg))
                             * jrd_pkg::SUM_W'(MAG_W'(vx_reg[AX_W-1] ? -vx_reg : vx_reg));
                    sqy_reg <= jrd_pkg::SUM_W'(MAG_W'(vy_reg[AX_W-1] ? -vy_reg : vy_reg))
                             * jrd_pkg::SUM_W'(MAG_W'(vy_reg[AX_W-1] ? -vy_reg : vy_reg));
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    n_reg     <= sqx_reg + sqy_reg;
                    res_reg   <= '0;
                    bit_reg   <= jrd_pkg::SUM_W'(1) << (jrd_pkg::SUM_W - 2);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (n_reg >= res_reg + bit_reg)
                    begin
                        n_reg   <= trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                        state_reg <= S_LEN;
                end
                S_LEN:
                begin
                    r_reg <= res_reg[jrd_pkg::R_W-1:0];
                    state_reg <= S_LWAIT;
                    if (!cfg.deadzone[16] && res_reg[jrd_pkg::R_W-1:0] > jrd_pkg::R_W'(dz24))
                    begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= jrd_pkg::NUM_W'(res_reg[jrd_pkg::R_W-1:0]
                                             - jrd_pkg::R_W'(dz24)) << 28;
                        div_req_reg.den   <= len_den[jrd_pkg::DEN_W-1:0];
                    end
                    else
                    begin
                        cx_reg    <= '0;
                        cy_reg    <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_LWAIT:
                begin
                    if (div_rsp.done && in_zone)
                    begin
                        f_reg <= (div_rsp.quot > (jrd_pkg::NUM_W'(1) << 24))
                               ? (F_W'(1) << 24) : div_rsp.quot[F_W-1:0];
                        sel_reg   <= 1'b0;
                        state_reg <= S_SCL;
                    end
                end
                S_SCL:
                begin
                    div_req_reg.start <= 1'b1;
                    div_req_reg.num   <= jrd_pkg::NUM_W'(sel_mag) * jrd_pkg::NUM_W'(f_reg);
                    div_req_reg.den   <= jrd_pkg::DEN_W'(r_reg);
                    state_reg         <= S_SWAIT;
                end
                S_SWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (sel_reg)
                        begin
                            cy_reg    <= scl_c;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            cx_reg    <= scl_c;
                            sel_reg   <= 1'b1;
                            state_reg <= S_SCL;
                        end
                    end
                end
                S_OUT:
                begin
                    if (slot_free)
                    begin
                        sx_reg        <= to_out(cx_reg);
                        sy_reg        <= to_out(cy_reg);
                        dir_reg       <= {cy_reg < -thr_c, cy_reg > thr_c,
                                          cx_reg < -thr_c, cx_reg > thr_c};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/joystick_radial_deadzone.sv -----
// ----------------------------------------------------------------------------
// joystick_radial_deadzone: analog stick conditioning with radial deadzone
// Each new sample passes through the 56-step shared divider (up to five
// divides) and the 28-step square root; one sample at a time.
// Repeated samples are absorbed at intake.
// Reset clears configuration to defaults, the last-sample record and all queues.
// ----------------------------------------------------------------------------
module joystick_radial_deadzone #(
    parameter int SAMPLE_BITS  = 16,
    parameter int OUTPUT_SCALE = 272
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [jrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jrd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [SAMPLE_BITS-1:0]            raw_x_in,
    input  logic [SAMPLE_BITS-1:0]            raw_y_in,
    output logic                              empty,
    input  logic                              pop,
    output logic [jrd_pkg::OUT_W-1:0]         stick_x,
    output logic [jrd_pkg::OUT_W-1:0]         stick_y,
    output logic                              dir_right,
    output logic                              dir_left,
    output logic                              dir_up,
    output logic                              dir_down
);

    jrd_pkg::cfg_t          cfg_reg;
    jrd_pkg::div_req_t      div_req;
    jrd_pkg::div_rsp_t      div_rsp;
    logic                   q_valid, q_pop;
    logic [SAMPLE_BITS-1:0] q_x, q_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_center      <= '0;
            cfg_reg.y_center      <= '0;
            cfg_reg.deadzone      <= '0;
            cfg_reg.range_divisor <= 16'd4096;
            cfg_reg.threshold     <= 15'd16384;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jrd_pkg::REG_X_OFFSET:  cfg_reg.x_center      <= cfg_data[15:0];
                jrd_pkg::REG_Y_OFFSET:  cfg_reg.y_center      <= cfg_data[15:0];
                jrd_pkg::REG_DEADZONE:  cfg_reg.deadzone      <= cfg_data;
                jrd_pkg::REG_RANGE:     cfg_reg.range_divisor <= cfg_data[15:0];
                jrd_pkg::REG_THRESHOLD: cfg_reg.threshold     <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    jrd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .raw_x_in(raw_x_in), .raw_y_in(raw_y_in),
        .q_valid(q_valid), .q_pop(q_pop), .q_x(q_x), .q_y(q_y)
    );

    jrd_div u_div (
        .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
    );

    jrd_back #(.SAMPLE_BITS(SAMPLE_BITS), .OUTPUT_SCALE(OUTPUT_SCALE)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_x(q_x), .q_y(q_y),
        .div_req(div_req), .div_rsp(div_rsp),
        .empty(empty), .pop(pop),
        .stick_x(stick_x), .stick_y(stick_y),
        .dir_right(dir_right), .dir_left(dir_left),
        .dir_up(dir_up), .dir_down(dir_down)
    );

endmodule
